/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define I16_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle, consequent in the next.
`define I16_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/i16mm_pkg.sv */
// Shared types and constants for the int16 4x4 matrix-product tile.
// No dependencies.
`default_nettype none

package i16mm_pkg;

  localparam int unsigned TileDim   = 4;
  localparam int unsigned TileCells = TileDim * TileDim;
  localparam int unsigned CellW     = $clog2(TileCells);
  localparam int unsigned DimW      = $clog2(TileDim);

  typedef logic [31:0] pair_t;
  typedef logic [31:0] word_t;
  typedef logic [CellW-1:0] cell_idx_t;

  typedef pair_t [TileDim-1:0] pair_vec_t;
  // Two 32-bit products (low halves, high halves) for each tile cell.
  typedef word_t [TileCells-1:0][1:0] prod_arr_t;

  // Control that travels beside the product stage.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  localparam cell_idx_t LastCell = cell_idx_t'(TileCells - 1);

endpackage

`default_nettype wire

/* src/i16mm_if.sv */
// Stream interfaces for the int16 4x4 matrix-product tile.
// Depends on i16mm_pkg.
`default_nettype none

interface i16mm_in_if;
  logic              valid;
  logic              ready;
  i16mm_pkg::pair_t  a_row0_pair;
  i16mm_pkg::pair_t  a_row1_pair;
  i16mm_pkg::pair_t  a_row2_pair;
  i16mm_pkg::pair_t  a_row3_pair;
  i16mm_pkg::pair_t  b_col0_pair;
  i16mm_pkg::pair_t  b_col1_pair;
  i16mm_pkg::pair_t  b_col2_pair;
  i16mm_pkg::pair_t  b_col3_pair;
  logic              last_pair;

  modport source (
    output valid, a_row0_pair, a_row1_pair, a_row2_pair, a_row3_pair,
           b_col0_pair, b_col1_pair, b_col2_pair, b_col3_pair, last_pair,
    input  ready
  );
  modport sink (
    input  valid, a_row0_pair, a_row1_pair, a_row2_pair, a_row3_pair,
           b_col0_pair, b_col1_pair, b_col2_pair, b_col3_pair, last_pair,
    output ready
  );
endinterface

interface i16mm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         tile_row;
  logic [1:0]         tile_col;
  logic signed [31:0] dot_sum;
  logic               last_of_tile;

  modport source (
    output valid, tile_row, tile_col, dot_sum, last_of_tile,
    input  ready
  );
  modport sink (
    input  valid, tile_row, tile_col, dot_sum, last_of_tile,
    output ready
  );
endinterface

`default_nettype wire

/* src/i16mm_mul.sv */
// Input register and 32 parallel signed 16x16 multipliers, registered.
// Depends on i16mm_pkg and i16mm_in_if.
`default_nettype none

module i16mm_mul (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  i16mm_in_if.sink                   in_i,
  input  wire logic                  stall_i,
  output i16mm_pkg::stage_ctl_t      ctl_o,
  output i16mm_pkg::prod_arr_t       prod_o
);
  import i16mm_pkg::*;

  stage_ctl_t ctl_in_d, ctl_in_q;
  stage_ctl_t ctl_prod_d, ctl_prod_q;
  pair_vec_t  a_q, b_q;
  prod_arr_t  prod_d, prod_q;
  logic       in_fire;

  // Full 32-bit product of two int16 halves.
  function automatic word_t mul16(input logic [15:0] x, input logic [15:0] y);
    logic signed [31:0] p;
    p = $signed(x) * $signed(y);
    return word_t'(p);
  endfunction

  // Lockstep pipeline: everything holds while the accumulator stage stalls.
  assign in_i.ready = !stall_i;
  assign in_fire    = in_i.valid && !stall_i;

  always_comb begin
    ctl_in_d   = ctl_in_q;
    ctl_prod_d = ctl_prod_q;
    if (!stall_i) begin
      ctl_in_d.valid = in_fire;
      ctl_in_d.last  = in_i.last_pair;
      ctl_prod_d     = ctl_in_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_in_q   <= '0;
      ctl_prod_q <= '0;
    end else begin
      ctl_in_q   <= ctl_in_d;
      ctl_prod_q <= ctl_prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q <= {in_i.a_row3_pair, in_i.a_row2_pair, in_i.a_row1_pair, in_i.a_row0_pair};
      b_q <= {in_i.b_col3_pair, in_i.b_col2_pair, in_i.b_col1_pair, in_i.b_col0_pair};
    end
  end

  always_comb begin
    for (int r = 0; r < TileDim; r++) begin
      for (int c = 0; c < TileDim; c++) begin
        prod_d[r*TileDim+c][0] = mul16(a_q[r][15:0], b_q[c][15:0]);
        prod_d[r*TileDim+c][1] = mul16(a_q[r][31:16], b_q[c][31:16]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      prod_q <= prod_d;
    end
  end

  assign ctl_o  = ctl_prod_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* src/i16mm_acc.sv */
// Sixteen wrapping accumulators and the drain buffer that streams the sums.
// Depends on i16mm_pkg and i16mm_out_if.
`default_nettype none

module i16mm_acc (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire i16mm_pkg::stage_ctl_t ctl_i,
  input  wire i16mm_pkg::prod_arr_t  prod_i,
  output logic                       stall_o,
  i16mm_out_if.source                out_o
);
  import i16mm_pkg::*;

  word_t [TileCells-1:0] acc_d, acc_q;
  word_t [TileCells-1:0] sum;
  word_t [TileCells-1:0] drain_d, drain_q;
  cell_idx_t             cnt_d, cnt_q;
  logic                  busy_d, busy_q;
  logic                  capture, pop;

  // A tile end must wait until the previous tile has fully drained.
  assign stall_o = ctl_i.valid && ctl_i.last && busy_q;
  assign capture = ctl_i.valid && ctl_i.last && !busy_q;
  assign pop     = busy_q && out_o.ready;

  always_comb begin
    for (int k = 0; k < TileCells; k++) begin
      sum[k] = acc_q[k] + prod_i[k][0] + prod_i[k][1];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (capture) begin
      acc_d = '0;
    end else if (ctl_i.valid && !stall_o) begin
      acc_d = sum;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    drain_d = drain_q;
    if (capture) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      drain_d = sum;
    end else if (pop) begin
      cnt_d = cnt_q + cell_idx_t'(1);
      for (int k = 0; k < TileCells - 1; k++) begin
        drain_d[k] = drain_q[k+1];
      end
      if (cnt_q == LastCell) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drain_q <= drain_d;
  end

  assign out_o.valid        = busy_q;
  assign out_o.tile_row     = cnt_q[CellW-1:DimW];
  assign out_o.tile_col     = cnt_q[DimW-1:0];
  assign out_o.dot_sum      = $signed(drain_q[0]);
  assign out_o.last_of_tile = (cnt_q == LastCell);

endmodule

`default_nettype wire

/* src/int16_matmul_tile_4x4.sv */
// Top level of the int16 4x4 output-stationary matrix-product tile.
// Depends on i16mm_pkg, i16mm_if, i16mm_mul and i16mm_acc.
`default_nettype none

// Takes one input item per cycle while not stalled: four packed int16 pairs
// of A rows and four of B columns. An item passes an input register and a
// registered bank of 32 signed 16x16 multipliers, then updates sixteen
// 32-bit wrapping accumulators. On an item with last_pair set the sums are
// copied into a drain buffer and the accumulators clear; the buffer sends 16
// results, row-major, one per cycle while the output is ready, and input
// keeps flowing meanwhile. The drain buffer holds one tile, so a tile end
// reaching the accumulators while the previous tile is still draining stalls
// the input until that drain completes: with the output always ready, tiles
// of 17 or more items run at one item per cycle.
module int16_matmul_tile_4x4 (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  i16mm_in_if.sink    in_i,
  i16mm_out_if.source out_o
);
  import i16mm_pkg::*;

  stage_ctl_t ctl;
  prod_arr_t  prod;
  logic       stall;

  i16mm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stall_i(stall),
    .ctl_o  (ctl),
    .prod_o (prod)
  );

  i16mm_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .prod_i (prod),
    .stall_o(stall),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

/* src/i16mm_check.sv */
// Port-level checker for the int16 4x4 matrix-product tile, with its bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i16mm_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  tile_row,
  input wire logic [1:0]  tile_col,
  input wire logic [31:0] dot_sum,
  input wire logic        last_of_tile
);

  // A drain runs without gaps once started.
  `I16_ASSERT_NEXT(a_drain_cont, clk_i, rst_ni, out_valid && out_ready && !last_of_tile, out_valid)
  // Columns step by one within a row.
  `I16_ASSERT_NEXT(a_col_step, clk_i, rst_ni, out_valid && out_ready && !last_of_tile, tile_col == 2'($past(tile_col) + 2'd1))
  // The tile's final request is the bottom-right cell.
  `I16_ASSERT(a_last_cell, clk_i, rst_ni, !(out_valid && last_of_tile) || (tile_row == 2'd3 && tile_col == 2'd3))
  // A stalled request holds its sum.
  `I16_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(dot_sum))

endmodule

bind int16_matmul_tile_4x4 i16mm_check u_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .tile_row    (out_o.tile_row),
  .tile_col    (out_o.tile_col),
  .dot_sum     (out_o.dot_sum),
  .last_of_tile(out_o.last_of_tile)
);

`default_nettype wire
